### hw/rtl/ir_distance_steering_defines.svh
// ----------------------------------------------------------------------------
// ir_distance_steering_defines.svh
// Assertion macros used by the checker file of the distance steering block.
// ----------------------------------------------------------------------------
`ifndef IR_DISTANCE_STEERING_DEFINES_SVH
`define IR_DISTANCE_STEERING_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IDS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/ids_pkg.sv
// ----------------------------------------------------------------------------
// ids_pkg
// Types, widths and constants of the IR distance steering block.
// ----------------------------------------------------------------------------
`default_nettype none

package ids_pkg;

	localparam int READING_BITS_DEF = 12;

	localparam int CFG_W      = 16;
	localparam int APB_DATA_W = 32;
	localparam int PADDR_W    = 4;

	localparam int DIST_W  = 16;
	localparam int SPEED_W = 16;

	// Polynomial datapath: x is signed Q16, the accumulator signed Q16.
	localparam int FRAC_BITS  = 16;
	localparam int X_W        = 19;
	localparam int ACC_W      = 32;
	localparam int PROD_W     = ACC_W + X_W;
	localparam int N_W        = 25;
	localparam int DIST_SHIFT = 10;
	localparam int POLY_ORDER = 6;
	localparam int STEP_W     = 3;

	// x = (100 * code - 56 * 2^bits) * 2^16 / (24 * 2^bits)
	localparam int unsigned NORM_SCALE  = 100;
	localparam int unsigned NORM_OFFSET = 56;
	localparam int unsigned NORM_DEN    = 24;

	// Division by 24 is a shift by three and a division by 3. For n below 2^21,
	// floor(n / 3) equals (n * NORM_RECIP) >> NORM_RECIP_SHIFT.
	localparam int NORM_DEN_SHIFT   = 3;
	localparam int RECIP_W          = 20;
	localparam int NORM_RECIP_SHIFT = 21;
	localparam logic [RECIP_W-1:0] NORM_RECIP = 20'd699051;

	localparam int DIV_NUM_W = 24;
	localparam int DIV_DEN_W = 16;
	localparam int SUM_W     = DIV_NUM_W + 2;
	localparam int GAIN_SHIFT = 8;

	localparam logic signed [SPEED_W-1:0] SPEED_MAX = 16'sd16384;
	localparam logic [DIV_NUM_W-1:0] TERM_UNBOUNDED = DIV_NUM_W'(1) << 20;

	localparam logic signed [ACC_W-1:0] POLY_COEF [0:POLY_ORDER] = '{
		32'sd117965, -32'sd373555, 32'sd176947, 32'sd144179,
		32'sd308019, -32'sd851968, 32'sd1376256
	};

	localparam logic [CFG_W-1:0] NEAR_THRESHOLD_RST = 16'd4800;
	localparam logic [CFG_W-1:0] BASE_SPEED_RST     = 16'd8192;
	localparam logic [CFG_W-1:0] STEER_GAIN_RST     = 16'd12288;

	typedef enum logic [1:0] {
		REG_NEAR_THRESHOLD = 2'd0,
		REG_BASE_SPEED     = 2'd1,
		REG_STEER_GAIN     = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		ACT_CRUISE     = 2'd0,
		ACT_TURN_RIGHT = 2'd1,
		ACT_TURN_LEFT  = 2'd2,
		ACT_HOLD       = 2'd3
	} action_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_NUM_W-1:0] quot;
	} div_rsp_t;

endpackage

`default_nettype wire

### hw/rtl/ids_if.sv
// ----------------------------------------------------------------------------
// ids_if
// Valid/ready channels carrying sensor words in and steering words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ids_in_if import ids_pkg::*; #(
	parameter int READING_BITS = READING_BITS_DEF
) ();
	logic                    valid;
	logic                    ready;
	logic [READING_BITS-1:0] reading_left;
	logic [READING_BITS-1:0] reading_center;
	logic [READING_BITS-1:0] reading_right;

	modport source (output valid, reading_left, reading_center, reading_right, input ready);
	modport sink   (input valid, reading_left, reading_center, reading_right, output ready);
endinterface

interface ids_out_if import ids_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [DIST_W-1:0]         dist_left;
	logic [DIST_W-1:0]         dist_center;
	logic [DIST_W-1:0]         dist_right;
	logic signed [SPEED_W-1:0] speed_left;
	logic signed [SPEED_W-1:0] speed_right;
	action_t                   action;

	modport source (
		output valid, dist_left, dist_center, dist_right, speed_left, speed_right, action,
		input ready
	);
	modport sink (
		input valid, dist_left, dist_center, dist_right, speed_left, speed_right, action,
		output ready
	);
endinterface

`default_nettype wire

### hw/rtl/ids_div.sv
// ----------------------------------------------------------------------------
// ids_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ids_div import ids_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(DIV_NUM_W + 1);

	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DIV_DEN_W:0] trial;
	logic [DIV_DEN_W:0] diff;
	logic               fits;

	// Shift in the next numerator bit and try to take the divisor away.
	assign trial = {rem_q, quo_q[DIV_NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = !diff[DIV_DEN_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
			rem_q <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

endmodule

`default_nettype wire

### hw/rtl/ir_distance_steering.sv
// ----------------------------------------------------------------------------
// ir_distance_steering
// Words are taken one at a time: a new sensor word is accepted only once the
// last one has run its three distance passes and, when steering needs a
// quotient, the serial divide, and its result has entered the output register.
// Reset: arst_n idles the sequencer, drops the result valid, zeroes the held
// speeds and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

// Overview
// Each sensor word holds a left, a center and a right IR code. The three codes
// are handled one after the other by the same datapath:
//   1. The code is turned into a signed numerator, which is divided by 24 with
//      rounding to give x in Q16. The division is a shift by three followed
//      by a reciprocal multiplication for the remaining factor of 3.
//   2. A sixth-degree polynomial in x is evaluated by Horner's rule on a single
//      signed multiplier: the MUL state multiplies into a product register,
//      and the ADD state rounds the product back to Q16 and adds the next coefficient.
//   3. The Q16 result is rounded to Q10.6 centimeters and saturated.
// Once all three distances are known, the steering step compares them with
// the near threshold. When something is near, the wheel speeds are pushed
// apart by steer_gain * 2^8 over the distance of the nearer side, which uses
// the serial divider; equal side distances then hold the previous speeds.
// A finished result sits in the output register until it is taken; the
// sequencer may already accept and work on the next word meanwhile.

module ir_distance_steering import ids_pkg::*; #(
	parameter int READING_BITS = READING_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,

	// Configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,

	// Word channels
	ids_in_if.sink                sensor,
	ids_out_if.source             result
);

	localparam int XP_W = DIV_NUM_W - NORM_DEN_SHIFT + RECIP_W;

	// One-hot sequencer states.
	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_XLOAD = 9'b000000010,
		ST_XDIV  = 9'b000000100,
		ST_MUL   = 9'b000001000,
		ST_ADD   = 9'b000010000,
		ST_DIST  = 9'b000100000,
		ST_STEER = 9'b001000000,
		ST_SDIV  = 9'b010000000,
		ST_FIN   = 9'b100000000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [CFG_W-1:0]          near_threshold_q;
	logic signed [SPEED_W-1:0] base_speed_q;
	logic [CFG_W-1:0]          steer_gain_q;

	// Held wheel speeds from the last result.
	logic signed [SPEED_W-1:0] held_speed_left_q;
	logic signed [SPEED_W-1:0] held_speed_right_q;

	// Captured sensor codes and the index of the code in progress.
	logic [READING_BITS-1:0] code_left_q;
	logic [READING_BITS-1:0] code_center_q;
	logic [READING_BITS-1:0] code_right_q;
	logic [1:0]              sel_q;

	// Polynomial datapath.
	logic                     n_neg_q;
	logic [DIV_NUM_W-1:0]     n_mag_q;
	logic signed [X_W-1:0]    x_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [PROD_W-1:0] prod_s1;
	logic [STEP_W-1:0]        step_q;

	// Distances and steering.
	logic [DIST_W-1:0]    dist_left_q;
	logic [DIST_W-1:0]    dist_center_q;
	logic [DIST_W-1:0]    dist_right_q;
	logic [DIV_NUM_W-1:0] term_q;
	action_t              action_q;

	// Output register.
	logic                      out_valid_q;
	logic [DIST_W-1:0]         out_dist_left_q;
	logic [DIST_W-1:0]         out_dist_center_q;
	logic [DIST_W-1:0]         out_dist_right_q;
	logic signed [SPEED_W-1:0] out_speed_left_q;
	logic signed [SPEED_W-1:0] out_speed_right_q;
	action_t                   out_action_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	ids_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// ------------------------------------------------------------------------
	// Configuration port. pready is tied high, so every access completes
	// without wait states. Addresses beyond the last register are ignored on
	// write and read as zero.
	// ------------------------------------------------------------------------
	logic     cfg_wr;
	reg_idx_t cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_threshold_q <= NEAR_THRESHOLD_RST;
			base_speed_q     <= BASE_SPEED_RST;
			steer_gain_q     <= STEER_GAIN_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_NEAR_THRESHOLD: near_threshold_q <= pwdata[CFG_W-1:0];
				REG_BASE_SPEED:     base_speed_q     <= pwdata[CFG_W-1:0];
				REG_STEER_GAIN:     steer_gain_q     <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_NEAR_THRESHOLD: prdata = APB_DATA_W'(near_threshold_q);
			REG_BASE_SPEED:     prdata = APB_DATA_W'(unsigned'(base_speed_q));
			REG_STEER_GAIN:     prdata = APB_DATA_W'(steer_gain_q);
			default:            prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------------
	// Normalization. The numerator (100 * code - 56 * 2^bits) * 2^(16 - bits)
	// is exact; its magnitude plus half of 24 is registered, and the next
	// cycle divides it by 24, so the quotient is rounded to nearest with ties
	// away from zero. The division drops three bits and multiplies by the
	// reciprocal of 3, which is exact over the whole numerator range.
	// ------------------------------------------------------------------------
	logic [READING_BITS-1:0]             code_cur;
	logic [N_W-1:0]                      n_raw;
	logic                                n_neg;
	logic [DIV_NUM_W-1:0]                n_mag;
	logic [DIV_NUM_W-NORM_DEN_SHIFT-1:0] n_div8;
	logic [XP_W-1:0]                     x_prod;
	logic [X_W-1:0]                      x_mag;

	always_comb begin
		unique case (sel_q)
			2'd0:    code_cur = code_left_q;
			2'd1:    code_cur = code_center_q;
			default: code_cur = code_right_q;
		endcase
	end

	assign n_raw = (N_W'(code_cur) * N_W'(NORM_SCALE) - (N_W'(NORM_OFFSET) << READING_BITS))
		<< (FRAC_BITS - READING_BITS);
	assign n_neg = n_raw[N_W-1];
	assign n_mag = DIV_NUM_W'(n_neg ? (N_W'(0) - n_raw) : n_raw) + DIV_NUM_W'(NORM_DEN / 2);

	assign n_div8 = n_mag_q[DIV_NUM_W-1:NORM_DEN_SHIFT];
	assign x_prod = XP_W'(n_div8) * XP_W'(NORM_RECIP);
	assign x_mag  = x_prod[NORM_RECIP_SHIFT +: X_W];

	// ------------------------------------------------------------------------
	// Horner step. The product is rounded back to Q16, ties away from zero:
	// a negative value takes one less as its bias before the arithmetic shift.
	// ------------------------------------------------------------------------
	logic signed [PROD_W-1:0] prod_bias;
	logic signed [PROD_W-1:0] prod_rnd;
	logic signed [ACC_W-1:0]  acc_next;

	assign prod_bias = prod_s1[PROD_W-1] ? PROD_W'((1 << (FRAC_BITS - 1)) - 1)
	                                      : PROD_W'(1 << (FRAC_BITS - 1));
	assign prod_rnd  = prod_s1 + prod_bias;
	assign acc_next  = ACC_W'(prod_rnd >>> FRAC_BITS) + POLY_COEF[step_q];

	// Distance: Q16 rounded to Q10.6 the same way, then clamped to 0..65535.
	logic signed [ACC_W-1:0] dist_bias;
	logic signed [ACC_W-1:0] dist_rnd;
	logic [DIST_W-1:0]       dist_sat;

	assign dist_bias = acc_q[ACC_W-1] ? ACC_W'((1 << (DIST_SHIFT - 1)) - 1)
	                                   : ACC_W'(1 << (DIST_SHIFT - 1));
	assign dist_rnd  = (acc_q + dist_bias) >>> DIST_SHIFT;

	always_comb begin
		if (dist_rnd[ACC_W-1]) begin
			dist_sat = '0;
		end else if (|dist_rnd[ACC_W-2:DIST_W]) begin
			dist_sat = '1;
		end else begin
			dist_sat = dist_rnd[DIST_W-1:0];
		end
	end

	// ------------------------------------------------------------------------
	// Steering decision. The nearer side sets the correction; a zero distance
	// skips the divider and takes a term large enough to saturate both wheels.
	// ------------------------------------------------------------------------
	logic              near;
	logic              left_nearer;
	logic              right_nearer;
	logic [DIST_W-1:0] d_near;
	logic              steer_div;

	assign near = (dist_left_q < near_threshold_q) || (dist_center_q < near_threshold_q)
		|| (dist_right_q < near_threshold_q);
	assign left_nearer  = dist_left_q < dist_right_q;
	assign right_nearer = dist_right_q < dist_left_q;
	assign d_near       = left_nearer ? dist_left_q : dist_right_q;
	assign steer_div    = near && (left_nearer || right_nearer) && (d_near != '0);

	// The divider computes the steering gain, shifted up by GAIN_SHIFT, over the nearer distance.
	always_comb begin
		div_req.start = (state_q == ST_STEER) && steer_div;
		div_req.num   = DIV_NUM_W'(steer_gain_q) << GAIN_SHIFT;
		div_req.den   = d_near;
	end

	// ------------------------------------------------------------------------
	// Wheel speeds: base plus or minus the correction, saturated to +/-1.0; a hold repeats the held speeds.
	// ------------------------------------------------------------------------
	function automatic logic signed [SPEED_W-1:0] sat_speed(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] lim;
		lim = SUM_W'(SPEED_MAX);
		if (v > lim) begin
			return SPEED_MAX;
		end else if (v < -lim) begin
			return -SPEED_MAX;
		end else begin
			return SPEED_W'(v);
		end
	endfunction

	logic signed [SUM_W-1:0]   base_ext;
	logic signed [SUM_W-1:0]   term_ext;
	logic signed [SPEED_W-1:0] speed_plus;
	logic signed [SPEED_W-1:0] speed_minus;
	logic signed [SPEED_W-1:0] speed_left_nxt;
	logic signed [SPEED_W-1:0] speed_right_nxt;

	assign base_ext    = SUM_W'(base_speed_q);
	assign term_ext    = signed'(SUM_W'(term_q));
	assign speed_plus  = sat_speed(base_ext + term_ext);
	assign speed_minus = sat_speed(base_ext - term_ext);

	always_comb begin
		unique case (action_q)
			ACT_TURN_RIGHT: begin
				speed_left_nxt  = speed_plus;
				speed_right_nxt = speed_minus;
			end
			ACT_TURN_LEFT: begin
				speed_left_nxt  = speed_minus;
				speed_right_nxt = speed_plus;
			end
			ACT_HOLD: begin
				speed_left_nxt  = held_speed_left_q;
				speed_right_nxt = held_speed_right_q;
			end
			ACT_CRUISE: begin
				// The term is zero here, so this is the saturated base speed.
				speed_left_nxt  = speed_plus;
				speed_right_nxt = speed_plus;
			end
		endcase
	end

	// ------------------------------------------------------------------------
	// Sequencer.
	// ------------------------------------------------------------------------
	logic in_fire;
	logic out_load;

	assign in_fire  = sensor.valid && sensor.ready;
	assign out_load = (state_q == ST_FIN) && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q            <= ST_IDLE;
			sel_q              <= '0;
			step_q             <= '0;
			held_speed_left_q  <= '0;
			held_speed_right_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						sel_q   <= '0;
						state_q <= ST_XLOAD;
					end
				end
				ST_XLOAD: begin
					state_q <= ST_XDIV;
				end
				ST_XDIV: begin
					step_q  <= STEP_W'(1);
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					if (step_q == STEP_W'(POLY_ORDER)) begin
						state_q <= ST_DIST;
					end else begin
						step_q  <= step_q + STEP_W'(1);
						state_q <= ST_MUL;
					end
				end
				ST_DIST: begin
					if (sel_q == 2'd2) begin
						state_q <= ST_STEER;
					end else begin
						sel_q   <= sel_q + 2'd1;
						state_q <= ST_XLOAD;
					end
				end
				ST_STEER: begin
					state_q <= steer_div ? ST_SDIV : ST_FIN;
				end
				ST_SDIV: begin
					if (div_rsp.done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						held_speed_left_q  <= speed_left_nxt;
						held_speed_right_q <= speed_right_nxt;
						state_q            <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers, loaded under the sequencer's control.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			code_left_q   <= sensor.reading_left;
			code_center_q <= sensor.reading_center;
			code_right_q  <= sensor.reading_right;
		end
		if (state_q == ST_XLOAD) begin
			n_neg_q <= n_neg;
			n_mag_q <= n_mag;
		end
		if (state_q == ST_XDIV) begin
			x_q   <= n_neg_q ? -signed'(x_mag) : signed'(x_mag);
			acc_q <= POLY_COEF[0];
		end
		if (state_q == ST_MUL) begin
			prod_s1 <= acc_q * x_q;
		end
		if (state_q == ST_ADD) begin
			acc_q <= acc_next;
		end
		if (state_q == ST_DIST) begin
			unique case (sel_q)
				2'd0:    dist_left_q   <= dist_sat;
				2'd1:    dist_center_q <= dist_sat;
				default: dist_right_q  <= dist_sat;
			endcase
		end
		if (state_q == ST_STEER) begin
			if (!near) begin
				action_q <= ACT_CRUISE;
			end else if (left_nearer) begin
				action_q <= ACT_TURN_RIGHT;
			end else if (right_nearer) begin
				action_q <= ACT_TURN_LEFT;
			end else begin
				action_q <= ACT_HOLD;
			end
			term_q <= (near && (d_near == '0)) ? TERM_UNBOUNDED : '0;
		end
		if ((state_q == ST_SDIV) && div_rsp.done) begin
			term_q <= div_rsp.quot;
		end
	end

	// ------------------------------------------------------------------------
	// Output register. A new result loads when the slot is empty or the word
	// in it is taken in the same cycle.
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_dist_left_q   <= dist_left_q;
			out_dist_center_q <= dist_center_q;
			out_dist_right_q  <= dist_right_q;
			out_speed_left_q  <= speed_left_nxt;
			out_speed_right_q <= speed_right_nxt;
			out_action_q      <= action_q;
		end
	end

	assign sensor.ready       = (state_q == ST_IDLE);
	assign result.valid       = out_valid_q;
	assign result.dist_left   = out_dist_left_q;
	assign result.dist_center = out_dist_center_q;
	assign result.dist_right  = out_dist_right_q;
	assign result.speed_left  = out_speed_left_q;
	assign result.speed_right = out_speed_right_q;
	assign result.action      = out_action_q;

endmodule

`default_nettype wire

### hw/rtl/ids_chk.sv
// ----------------------------------------------------------------------------
// ids_chk
// Port-level checks on the distance steering block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ir_distance_steering_defines.svh"

module ids_chk import ids_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      sensor_valid,
	input logic                      sensor_ready,
	input logic                      result_valid,
	input logic                      result_ready,
	input logic signed [SPEED_W-1:0] speed_left,
	input logic signed [SPEED_W-1:0] speed_right,
	input action_t                   action
);

	// Speeds of the last word delivered; a hold must repeat them.
	logic signed [SPEED_W-1:0] last_left_q;
	logic signed [SPEED_W-1:0] last_right_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_left_q  <= '0;
			last_right_q <= '0;
		end else if (result_valid && result_ready) begin
			last_left_q  <= speed_left;
			last_right_q <= speed_right;
		end
	end

	`IDS_ASSERT_NEXT(a_out_stall_holds, clk, arst_n, result_valid && !result_ready,
		result_valid && $stable(speed_left) && $stable(speed_right) && $stable(action),
		"result word changed while stalled")

	`IDS_ASSERT_NEXT(a_one_in_flight, clk, arst_n, sensor_valid && sensor_ready,
		!sensor_ready, "sensor word accepted while another is in progress")

	`IDS_ASSERT_NOW(a_speed_range, clk, arst_n, result_valid,
		speed_left <= SPEED_MAX && speed_left >= -SPEED_MAX &&
		speed_right <= SPEED_MAX && speed_right >= -SPEED_MAX,
		"wheel speed outside saturation range")

	`IDS_ASSERT_NOW(a_hold_repeats, clk, arst_n, result_valid && action == ACT_HOLD,
		speed_left == last_left_q && speed_right == last_right_q,
		"hold action did not repeat the previous speeds")

	`IDS_ASSERT_NOW(a_cruise_equal, clk, arst_n, result_valid && action == ACT_CRUISE,
		speed_left == speed_right, "cruise action with unequal wheel speeds")

endmodule

bind ir_distance_steering ids_chk u_ids_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.sensor_valid(sensor.valid),
	.sensor_ready(sensor.ready),
	.result_valid(result.valid),
	.result_ready(result.ready),
	.speed_left  (result.speed_left),
	.speed_right (result.speed_right),
	.action      (result.action)
);

`default_nettype wire
